// ----- hw/rtl/rsa_pkg.sv -----
package rsa_pkg;

  localparam int Width = 32;
  localparam int CntW = $clog2(Width);

  localparam logic [1:0] RegModulus = 2'd0;
  localparam logic [1:0] RegPubExp  = 2'd1;
  localparam logic [1:0] RegPrivExp = 2'd2;

  // One job handed from the front end to the exponentiation engine.
  typedef struct packed {
    logic [Width-1:0] base;
    logic [Width-1:0] expo;
    logic [Width-1:0] modulus;
  } job_t;

  // (a + b) mod m, with a, b < m.
  function automatic logic [Width-1:0] add_mod(input logic [Width-1:0] a,
                                               input logic [Width-1:0] b,
                                               input logic [Width-1:0] m);
    logic [Width-1:0] room;
    room = m - b;
    if (a >= room) begin
      add_mod = a - room;
    end else begin
      add_mod = a + b;
    end
  endfunction

endpackage

// ----- hw/rtl/rsa_front.sv -----
module rsa_front
  import rsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [Width-1:0] cfg_data,
  input  logic             action,
  input  logic [Width-1:0] value,
  output job_t             job,
  output logic             job_zero
);

  logic [Width-1:0] modulus;
  logic [Width-1:0] public_exponent;
  logic [Width-1:0] private_exponent;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= Width'(2);
      public_exponent <= '0;
      private_exponent <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegModulus: modulus <= cfg_data;
        RegPubExp:  public_exponent <= cfg_data;
        RegPrivExp: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classification: pick the exponent, flag a zero modulus.
  always_comb begin
    job.base = value;
    job.expo = action ? private_exponent : public_exponent;
    job.modulus = modulus;
    job_zero = (modulus == '0);
  end

endmodule

// ----- hw/rtl/rsa_queue.sv -----
module rsa_queue
  import rsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic push_zero,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head,
  output logic head_zero
);

  // Single-entry holding stage between front end and engine.
  logic occupied;
  job_t data;
  logic zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (push) begin
      occupied <= 1'b1;
    end else if (pop) begin
      occupied <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_job;
      zero <= push_zero;
    end
  end

  assign full = occupied && !pop;
  assign empty = !occupied;
  assign head = data;
  assign head_zero = zero;

endmodule

// ----- hw/rtl/rsa_engine.sv -----
module rsa_engine
  import rsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  job_t             job,
  input  logic             job_zero,
  output logic             job_take,
  output logic             done,
  output logic [Width-1:0] result
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StReduce = 3'd1;
  localparam logic [2:0] StSquare = 3'd2;
  localparam logic [2:0] StMult   = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0]       state;
  logic [Width-1:0] m;
  logic [Width-1:0] expo;
  logic [Width-1:0] base;
  logic [Width-1:0] acc;
  logic [Width-1:0] prod;
  logic [Width-1:0] mplier;
  logic [CntW-1:0]  ebit;
  logic [CntW-1:0]  mbit;
  logic [Width-1:0] prod_next;
  logic [Width-1:0] addend;

  assign job_take = (state == StIdle) && job_valid;

  // One shift-and-add step of the modular multiplier. Base reduction
  // reuses it with an addend of one, which folds the base in bit by bit.
  always_comb begin
    if (state == StReduce) begin
      addend = Width'(1);
    end else if (state == StMult) begin
      addend = base;
    end else begin
      addend = acc;
    end
    prod_next = add_mod(prod, prod, m);
    if (mplier[mbit]) begin
      prod_next = add_mod(prod_next, addend, m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      done <= 1'b0;
    end else begin
      done <= (state == StDone);
      unique case (state)
        StIdle: begin
          if (job_valid) begin
            m <= job.modulus;
            expo <= job.expo;
            ebit <= CntW'(Width - 1);
            if (job_zero) begin
              acc <= '0;
              state <= StDone;
            end else begin
              base <= '0;
              prod <= '0;
              mplier <= job.base;
              mbit <= CntW'(Width - 1);
              acc <= (job.modulus == Width'(1)) ? '0 : Width'(1);
              state <= StReduce;
            end
          end
        end
        StReduce: begin
          if (mbit == '0) begin
            base <= prod_next;
            prod <= '0;
            mplier <= acc;
            mbit <= CntW'(Width - 1);
            state <= StSquare;
          end else begin
            prod <= prod_next;
            mbit <= mbit - 1'b1;
          end
        end
        StSquare, StMult: begin
          if (mbit == '0) begin
            mbit <= CntW'(Width - 1);
            prod <= '0;
            if (state == StSquare && expo[ebit]) begin
              acc <= prod_next;
              mplier <= prod_next;
              state <= StMult;
            end else begin
              acc <= prod_next;
              mplier <= prod_next;
              if (ebit == '0) begin
                state <= StDone;
              end else begin
                ebit <= ebit - 1'b1;
                state <= StSquare;
              end
            end
          end else begin
            prod <= prod_next;
            mbit <= mbit - 1'b1;
          end
        end
        StDone: begin
          result <= acc;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rsa_modular_exponentiation.sv -----
// The engine reduces the base, then squares for each exponent bit from the top and
// multiplies by the base where the bit is set; a zero modulus skips this and gives 0.
// All steps run on the one bit-serial modular multiplier in the engine.
// The engine works on one job at a time; a second job is held in a one-entry queue.
// Reset (rst, synchronous) clears control state and sets modulus 2, both
// exponents 0. The result strobe lasts one cycle; the receiver cannot stall.
module rsa_modular_exponentiation
  import rsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [Width-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  logic             action,
  input  logic [Width-1:0] value,
  output logic             done,
  output logic [Width-1:0] result
);

  job_t fjob;
  logic fzero;
  job_t qjob;
  logic qzero;
  logic qfull;
  logic qempty;
  logic take;
  logic accept;

  assign busy = qfull;
  assign accept = start && !busy;

  rsa_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .action(action), .value(value),
    .job(fjob), .job_zero(fzero)
  );

  rsa_queue u_queue (
    .clk(clk), .rst(rst), .push(accept), .push_job(fjob), .push_zero(fzero),
    .pop(take), .full(qfull), .empty(qempty), .head(qjob), .head_zero(qzero)
  );

  rsa_engine u_engine (
    .clk(clk), .rst(rst), .job_valid(!qempty), .job(qjob), .job_zero(qzero),
    .job_take(take), .done(done), .result(result)
  );

endmodule
